// ===== sv/nnact_pkg.sv =====
// Shared constants, types and curve tables of the activation unit.
`default_nettype none

package nnact_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int SEG_BITS   = 6;
  localparam int SEGMENTS   = 2 ** SEG_BITS;
  localparam int OFF_BITS   = DATA_WIDTH - SEG_BITS;
  localparam int ENTRY_W    = DATA_WIDTH + 1;
  localparam int DIFF_W     = ENTRY_W + 1;
  localparam int PROD_W     = DIFF_W + OFF_BITS + 1;
  localparam int SUM_W      = PROD_W - OFF_BITS + 1;

  localparam logic [1:0] KIND_RELU = 2'd0;
  localparam logic [1:0] KIND_SILU = 2'd1;
  localparam logic [1:0] KIND_GELU = 2'd2;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) <<< (OFF_BITS - 1);
  localparam logic signed [SUM_W-1:0]  SAT_MAX    = SUM_W'((1 <<< (DATA_WIDTH - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  SAT_MIN    = SUM_W'(-(1 <<< (DATA_WIDTH - 1)));

  typedef logic signed [DATA_WIDTH-1:0] sample_t;
  typedef logic signed [ENTRY_W-1:0]    entry_t;
  typedef logic [SEG_BITS:0]            knot_t;

  // Word handed from the table lookup to the interpolation stages.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic                use_table;
    entry_t              base;
    entry_t              top;
    logic [OFF_BITS-1:0] off;
    sample_t             relu;
  } lookup_t;

  // SiLU sampled at the knots -8.0, -7.75, ..., +8.0 in Q4.12.
  function automatic entry_t silu_rom(input knot_t k);
    entry_t v;
    v = '0;
    case (k)
      0: v = entry_t'(-11);      1: v = entry_t'(-14);      2: v = entry_t'(-17);
      3: v = entry_t'(-21);      4: v = entry_t'(-26);      5: v = entry_t'(-32);
      6: v = entry_t'(-40);      7: v = entry_t'(-49);      8: v = entry_t'(-61);
      9: v = entry_t'(-75);      10: v = entry_t'(-92);     11: v = entry_t'(-112);
      12: v = entry_t'(-137);    13: v = entry_t'(-167);    14: v = entry_t'(-203);
      15: v = entry_t'(-245);    16: v = entry_t'(-295);    17: v = entry_t'(-353);
      18: v = entry_t'(-420);    19: v = entry_t'(-497);    20: v = entry_t'(-583);
      21: v = entry_t'(-677);    22: v = entry_t'(-777);    23: v = entry_t'(-879);
      24: v = entry_t'(-977);    25: v = entry_t'(-1061);   26: v = entry_t'(-1121);
      27: v = entry_t'(-1140);   28: v = entry_t'(-1102);   29: v = entry_t'(-986);
      30: v = entry_t'(-773);    31: v = entry_t'(-448);    32: v = entry_t'(0);
      33: v = entry_t'(576);     34: v = entry_t'(1275);    35: v = entry_t'(2086);
      36: v = entry_t'(2994);    37: v = entry_t'(3980);    38: v = entry_t'(5023);
      39: v = entry_t'(6107);    40: v = entry_t'(7215);    41: v = entry_t'(8337);
      42: v = entry_t'(9463);    43: v = entry_t'(10587);   44: v = entry_t'(11705);
      45: v = entry_t'(12815);   46: v = entry_t'(13916);   47: v = entry_t'(15007);
      48: v = entry_t'(16089);   49: v = entry_t'(17163);   50: v = entry_t'(18229);
      51: v = entry_t'(19289);   52: v = entry_t'(20343);   53: v = entry_t'(21392);
      54: v = entry_t'(22436);   55: v = entry_t'(23477);   56: v = entry_t'(24515);
      57: v = entry_t'(25551);   58: v = entry_t'(26584);   59: v = entry_t'(27616);
      60: v = entry_t'(28646);   61: v = entry_t'(29675);   62: v = entry_t'(30703);
      63: v = entry_t'(31730);   64: v = entry_t'(32757);
      default: v = '0;
    endcase
    return v;
  endfunction

  // GELU (tanh form) sampled at the same knots.
  function automatic entry_t gelu_rom(input knot_t k);
    entry_t v;
    v = '0;
    case (k)
      17: v = entry_t'(-1);      18: v = entry_t'(-3);      19: v = entry_t'(-6);
      20: v = entry_t'(-15);     21: v = entry_t'(-32);     22: v = entry_t'(-62);
      23: v = entry_t'(-111);    24: v = entry_t'(-186);    25: v = entry_t'(-288);
      26: v = entry_t'(-411);    27: v = entry_t'(-542);    28: v = entry_t'(-650);
      29: v = entry_t'(-696);    30: v = entry_t'(-632);    31: v = entry_t'(-411);
      32: v = entry_t'(0);       33: v = entry_t'(613);     34: v = entry_t'(1416);
      35: v = entry_t'(2376);    36: v = entry_t'(3446);    37: v = entry_t'(4578);
      38: v = entry_t'(5733);    39: v = entry_t'(6880);    40: v = entry_t'(8006);
      41: v = entry_t'(9105);    42: v = entry_t'(10178);   43: v = entry_t'(11232);
      44: v = entry_t'(12273);   45: v = entry_t'(13306);   46: v = entry_t'(14333);
      47: v = entry_t'(15359);   48: v = entry_t'(16384);   49: v = entry_t'(17408);
      50: v = entry_t'(18432);   51: v = entry_t'(19456);   52: v = entry_t'(20480);
      53: v = entry_t'(21504);   54: v = entry_t'(22528);   55: v = entry_t'(23552);
      56: v = entry_t'(24576);   57: v = entry_t'(25600);   58: v = entry_t'(26624);
      59: v = entry_t'(27648);   60: v = entry_t'(28672);   61: v = entry_t'(29696);
      62: v = entry_t'(30720);   63: v = entry_t'(31744);   64: v = entry_t'(32768);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/nnact_in_if.sv =====
// Input stream interface: one sample word with its end-of-tensor flag.
`default_nettype none

interface nnact_in_if;
  logic              valid;
  logic              ready;
  nnact_pkg::sample_t sample;
  logic              last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/nnact_out_if.sv =====
// Output stream interface: one activated word with its end-of-tensor flag.
`default_nettype none

interface nnact_out_if;
  logic              valid;
  logic              ready;
  nnact_pkg::sample_t activated;
  logic              last_out;

  modport source (output valid, output activated, output last_out, input ready);
  modport sink   (input valid, input activated, input last_out, output ready);
endinterface

`default_nettype wire

// ===== sv/nnact_lookup.sv =====
// Input capture stage and curve table lookup stage.
`default_nettype none

module nnact_lookup (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  nnact_pkg::sample_t  sample,
  input  logic                last,
  input  logic [1:0]          kind,
  output nnact_pkg::lookup_t  stage
);

  logic               cap_valid;
  nnact_pkg::sample_t cap_sample;
  logic               cap_last;
  logic [1:0]         cap_kind;

  logic [nnact_pkg::DATA_WIDTH-1:0] biased;
  nnact_pkg::knot_t                 knot_lo;
  nnact_pkg::knot_t                 knot_hi;
  nnact_pkg::lookup_t               stage_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else if (advance) begin
      cap_valid <= in_valid;
    end
    if (advance) begin
      cap_sample <= sample;
      cap_last   <= last;
      cap_kind   <= kind;
    end
  end

  // Offset binary code: the segment index is its top bits.
  assign biased  = {~cap_sample[nnact_pkg::DATA_WIDTH-1],
                    cap_sample[nnact_pkg::DATA_WIDTH-2:0]};
  assign knot_lo = {1'b0, biased[nnact_pkg::DATA_WIDTH-1 -: nnact_pkg::SEG_BITS]};
  assign knot_hi = knot_lo + (nnact_pkg::SEG_BITS + 1)'(1);

  always_comb begin
    stage_next       = '0;
    stage_next.valid = cap_valid;
    stage_next.last  = cap_last;
    stage_next.off   = biased[nnact_pkg::OFF_BITS-1:0];
    stage_next.relu  = cap_sample[nnact_pkg::DATA_WIDTH-1] ? '0 : cap_sample;
    case (cap_kind)
      nnact_pkg::KIND_SILU: begin
        stage_next.use_table = 1'b1;
        stage_next.base      = nnact_pkg::silu_rom(knot_lo);
        stage_next.top       = nnact_pkg::silu_rom(knot_hi);
      end
      nnact_pkg::KIND_GELU: begin
        stage_next.use_table = 1'b1;
        stage_next.base      = nnact_pkg::gelu_rom(knot_lo);
        stage_next.top       = nnact_pkg::gelu_rom(knot_hi);
      end
      default: begin
        stage_next.use_table = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (advance) begin
      stage.valid <= stage_next.valid;
    end
    if (advance) begin
      stage.last      <= stage_next.last;
      stage.use_table <= stage_next.use_table;
      stage.base      <= stage_next.base;
      stage.top       <= stage_next.top;
      stage.off       <= stage_next.off;
      stage.relu      <= stage_next.relu;
    end
  end

endmodule

`default_nettype wire

// ===== sv/nnact_interp.sv =====
// Slope multiply stage and interpolate, saturate and output register stage.
`default_nettype none

module nnact_interp (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  nnact_pkg::lookup_t stage,
  output logic               out_valid,
  output nnact_pkg::sample_t activated,
  output logic               last_out
);

  logic signed [nnact_pkg::DIFF_W-1:0]     diff;
  logic signed [nnact_pkg::OFF_BITS:0]     off_s;
  logic signed [nnact_pkg::PROD_W-1:0]     prod_next;

  logic                                    mul_valid;
  logic                                    mul_last;
  logic                                    mul_table;
  nnact_pkg::entry_t                       mul_base;
  nnact_pkg::sample_t                      mul_relu;
  logic signed [nnact_pkg::PROD_W-1:0]     prod;

  logic signed [nnact_pkg::PROD_W-1:0]     step;
  logic signed [nnact_pkg::SUM_W-1:0]      sum;
  nnact_pkg::sample_t                      sat;
  nnact_pkg::sample_t                      activated_next;

  assign diff      = nnact_pkg::DIFF_W'(stage.top) - nnact_pkg::DIFF_W'(stage.base);
  assign off_s     = $signed({1'b0, stage.off});
  assign prod_next = nnact_pkg::PROD_W'(diff) * nnact_pkg::PROD_W'(off_s)
                     + nnact_pkg::ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (advance) begin
      mul_valid <= stage.valid;
    end
    if (advance) begin
      mul_last  <= stage.last;
      mul_table <= stage.use_table;
      mul_base  <= stage.base;
      mul_relu  <= stage.relu;
      prod      <= prod_next;
    end
  end

  // Arithmetic shift floors the rounded product.
  assign step = prod >>> nnact_pkg::OFF_BITS;
  assign sum  = nnact_pkg::SUM_W'(mul_base) + nnact_pkg::SUM_W'(step);

  always_comb begin
    if (sum > nnact_pkg::SAT_MAX) begin
      sat = nnact_pkg::DATA_WIDTH'(nnact_pkg::SAT_MAX);
    end else if (sum < nnact_pkg::SAT_MIN) begin
      sat = nnact_pkg::DATA_WIDTH'(nnact_pkg::SAT_MIN);
    end else begin
      sat = nnact_pkg::DATA_WIDTH'(sum);
    end
    activated_next = mul_table ? sat : mul_relu;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= mul_valid;
    end
    if (advance) begin
      activated <= activated_next;
      last_out  <= mul_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/nn_activation_unit.sv =====
// Top level of the elementwise activation unit.
`default_nettype none

// Elementwise activation for signed Q4.12 words streamed over valid/ready.
// Each word accepted on sample_ch yields exactly one word on result_ch, in
// order, with the last flag copied through to last_out.
// The activation_kind register (cfg_we, cfg_wdata) picks ReLU (0), SiLU (1)
// or GELU in its tanh form (2); code 3 acts as ReLU. Write it only while the
// pipeline is empty. SiLU and GELU interpolate linearly between 65 knots of
// a fixed curve table spaced 0.25 apart over the whole input range, rounding
// to nearest; ReLU is exact.
// The datapath is a four-stage pipeline: input capture, table lookup, slope
// multiply, then add, saturate and the output register. One word can be
// accepted every cycle while the receiver keeps result_ch.ready high, so the
// sustained rate is one word per cycle.
// When the receiver holds result_ch.ready low, the whole pipeline freezes
// once the output register is full; words in flight keep their places and
// sample_ch.ready follows the freeze. While the output register is empty
// the pipeline keeps moving and fills its bubbles.
// Synchronous reset empties all stages and sets the register to ReLU.
module nn_activation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  nnact_in_if.sink           sample_ch,
  nnact_out_if.source        result_ch
);

  logic [1:0]         activation_kind;
  logic               advance;
  nnact_pkg::lookup_t lookup;

  always_ff @(posedge clk) begin
    if (rst) begin
      activation_kind <= nnact_pkg::KIND_RELU;
    end else if (cfg_we) begin
      activation_kind <= cfg_wdata;
    end
  end

  // All stages move together whenever the output register can take a word.
  assign advance         = !result_ch.valid || result_ch.ready;
  assign sample_ch.ready = advance;

  nnact_lookup u_lookup (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (sample_ch.valid),
    .sample   (sample_ch.sample),
    .last     (sample_ch.last),
    .kind     (activation_kind),
    .stage    (lookup)
  );

  nnact_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .stage     (lookup),
    .out_valid (result_ch.valid),
    .activated (result_ch.activated),
    .last_out  (result_ch.last_out)
  );

endmodule

`default_nettype wire

// ===== test/tb_nn_activation_unit.sv =====
// Self-checking testbench of the activation unit with its own curve predictor.
`timescale 1ns / 100ps

// The stimulus side feeds sample words from a queue, the response side checks
// every activated word against a predictor that rebuilds the SiLU and GELU
// knot tables from the fixed-point curve definitions and interpolates between
// them exactly as the block is specified to. Phases change the activation
// kind (only while the pipeline is empty) and the amount of idling on both
// sides of the block.
module tb_nn_activation_unit;

  // The spare selector code is specified to act as ReLU.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Fixed-point constants of the curve definitions; FRAC is the sample fraction width, the rest are in Q32.
  localparam int FRAC = 12;
  localparam longint unsigned ONE_Q32  = 64'd4294967296;
  localparam longint unsigned LN2_Q32  = 64'd2977044472;
  localparam longint unsigned K3_Q32   = 64'd192049463;
  localparam longint unsigned C2_Q32   = 64'd6853776189;
  localparam longint unsigned CLAMP_Q32 = 64'd32 << 32;

  // Four pipeline stages; DRAIN_WAIT gives spare time before a register write
  // and at the end of the run.
  localparam int LATENCY    = 4;
  localparam int DRAIN_WAIT = LATENCY + 2;
  // Length of the one long receiver hold-off that backs up the pipeline.
  localparam int LONG_HOLD  = 60;

  typedef struct {
    nnact_pkg::sample_t sample;
    logic               last;
  } in_word_t;

  typedef struct {
    nnact_pkg::sample_t activated;
    logic               last_out;
  } out_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every block input gets a known value from time zero through these variables.
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_wdata = nnact_pkg::KIND_RELU;
  logic               in_valid  = 1'b0;
  nnact_pkg::sample_t in_sample = '0;
  logic               in_last   = 1'b0;
  logic               out_ready = 1'b0;

  nnact_in_if  sample_ch ();
  nnact_out_if result_ch ();

  assign sample_ch.valid  = in_valid;
  assign sample_ch.sample = in_sample;
  assign sample_ch.last   = in_last;
  assign result_ch.ready  = out_ready;

  nn_activation_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be offered, and activated words still owed by the block.
  in_word_t  sample_queue[$];
  out_word_t activated_expected[$];

  // Shadow of the activation_kind register; it only changes while the block is idle.
  logic [1:0] kind_now = nnact_pkg::KIND_RELU;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int err_count = 0;

  // Curve values at the 65 knots, built once at time zero.
  longint silu_knots [0:nnact_pkg::SEGMENTS];
  longint gelu_knots [0:nnact_pkg::SEGMENTS];

  // exp(-a) in Q32: range reduction on ln2, then a 21-term Taylor series of the rest.
  function automatic longint unsigned exp_neg_q32(longint unsigned a);
    longint unsigned n, r, acc, term, i;
    n = a / LN2_Q32;
    r = a - n * LN2_Q32;
    acc = ONE_Q32;
    term = ONE_Q32;
    for (i = 1; i <= 20; i++) begin
      term = ((term * r) >> 32) / i;
      if (i[0]) acc -= term;
      else acc += term;
    end
    if (n >= 63) return 64'd0;
    return acc >> n;
  endfunction

  // Sigmoid of +/- mag in Q32, with the magnitude clamped to 32.
  function automatic longint unsigned sigmoid_q32(longint unsigned mag, bit neg);
    longint unsigned e, q;
    if (mag > CLAMP_Q32) mag = CLAMP_Q32;
    e = exp_neg_q32(mag);
    q = ((e << 31) / (ONE_Q32 + e)) << 1;
    return neg ? q : ONE_Q32 - q;
  endfunction

  // x times a Q32 factor, rounded to nearest with ties away from zero.
  function automatic longint scale_q32(longint x, longint unsigned p);
    bit neg;
    longint unsigned m, r;
    neg = x < 0;
    m = neg ? -x : x;
    r = (m * p + (64'd1 << 31)) >> 32;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint silu_at(longint x);
    longint unsigned mag, t;
    mag = (x < 0) ? -x : x;
    if (mag >= (64'd32 << FRAC)) t = CLAMP_Q32;
    else t = mag << (32 - FRAC);
    return scale_q32(x, sigmoid_q32(t, x < 0));
  endfunction

  // GELU through 0.5*(1+tanh(u)) = sigmoid(2u), u = sqrt(2/pi)*(x + 0.044715*x^3).
  function automatic longint gelu_at(longint x);
    longint unsigned mag, t, a, a2, inner, au;
    mag = (x < 0) ? -x : x;
    if (mag >= (64'd16 << FRAC)) begin
      t = CLAMP_Q32;
    end else begin
      a = mag << (32 - FRAC);
      a2 = ((a >> 8) * (a >> 8)) >> 16;
      inner = ONE_Q32 + ((K3_Q32 * (a2 >> 8)) >> 24);
      au = ((a >> 4) * (inner >> 4)) >> 24;
      t = ((au >> 8) * (C2_Q32 >> 8)) >> 16;
    end
    return scale_q32(x, sigmoid_q32(t, x < 0));
  endfunction

  // Expected activated word for one sample under a given selector code.
  function automatic nnact_pkg::sample_t activate_word(logic [1:0] kind,
                                                      nnact_pkg::sample_t s);
    longint x, y, lo, hi, off;
    int u, idx;
    x = s;
    if (kind == nnact_pkg::KIND_SILU || kind == nnact_pkg::KIND_GELU) begin
      u = int'(x) + (1 << (nnact_pkg::DATA_WIDTH - 1));
      idx = u >> nnact_pkg::OFF_BITS;
      off = u & ((1 << nnact_pkg::OFF_BITS) - 1);
      lo = (kind == nnact_pkg::KIND_SILU) ? silu_knots[idx] : gelu_knots[idx];
      hi = (kind == nnact_pkg::KIND_SILU) ? silu_knots[idx+1] : gelu_knots[idx+1];
      // Floor division by the segment width after adding half of it.
      y = lo + (((hi - lo) * off + (64'sd1 <<< (nnact_pkg::OFF_BITS - 1)))
                >>> nnact_pkg::OFF_BITS);
    end else begin
      y = (x > 0) ? x : 0;
    end
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return nnact_pkg::sample_t'(y);
  endfunction

  // Random samples: a mix of the full range, the bend near zero, and codes on,
  // beside or halfway between the knots, where the interpolation rounding is most exposed.
  function automatic nnact_pkg::sample_t pick_sample();
    int k;
    int near [6] = '{0, 1, 511, 512, 513, 1023};
    case ($urandom_range(3))
      0: return nnact_pkg::sample_t'($urandom);
      1: return nnact_pkg::sample_t'(int'($urandom_range(8191)) - 4096);
      2: begin
        k = $urandom_range(nnact_pkg::SEGMENTS - 1);
        return nnact_pkg::sample_t'(-32768 + k * 1024 + near[$urandom_range(5)]);
      end
      default: return nnact_pkg::sample_t'($urandom_range(65535));
    endcase
  endfunction

  // Stimulus side. The word on the port is held until the block takes it; each
  // taken word is predicted at once, with the register value it will see.
  always @(posedge clk) begin : sample_driver
    bit offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = !in_valid;
      if (in_valid && sample_ch.ready) begin
        activated_expected.push_back('{activated: activate_word(kind_now, in_sample),
                                       last_out: in_last});
        void'(sample_queue.pop_front());
        offer = 1'b1;
      end
      if (offer) begin
        if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          in_sample <= sample_queue[0].sample;
          in_last   <= sample_queue[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response side. Every activated word taken is checked against the oldest
  // expectation; ready then follows the stall setting or the long hold-off.
  always @(posedge clk) begin : result_monitor
    out_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (result_ch.valid && out_ready) begin
        if (activated_expected.size() == 0) begin
          err_count++;
          $display("%0t: unexpected word: activated %0d last_out %0b", $time,
                   result_ch.activated, result_ch.last_out);
        end else begin
          want = activated_expected.pop_front();
          if (result_ch.activated !== want.activated) begin
            err_count++;
            $display("%0t: activated mismatch: expected %0d actual %0d", $time,
                     want.activated, result_ch.activated);
          end
          if (result_ch.last_out !== want.last_out) begin
            err_count++;
            $display("%0t: last_out mismatch: expected %0b actual %0b", $time,
                     want.last_out, result_ch.last_out);
          end
        end
      end
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Waits until every queued word has been taken and every result has come
  // back, then lets the pipeline settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || activated_expected.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Register writes happen only on an empty pipeline. The shadow is switched
  // at a falling edge, after the write and before any new word can be taken.
  task automatic write_kind(logic [1:0] kind);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= kind;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    kind_now = kind;
  endtask

  // Extremes of the range, zero, minus one, an exact rounding tie and the last
  // code of a segment, ending with the end-of-tensor flag.
  task automatic queue_directed();
    int vals [6] = '{-32768, 32767, 0, -1, -512, 1023};
    @(negedge clk);
    foreach (vals[i])
      sample_queue.push_back('{sample: nnact_pkg::sample_t'(vals[i]),
                               last: (i % 2 == 1)});
  endtask

  task automatic queue_random(int count);
    @(negedge clk);
    repeat (count)
      sample_queue.push_back('{sample: pick_sample(), last: ($urandom_range(7) == 0)});
    sample_queue[$].last = 1'b1;
  endtask

  task automatic run_phase(logic [1:0] kind, int count, int send_pct, int stall);
    write_kind(kind);
    send_idle_pct = send_pct;
    stall_pct = stall;
    queue_random(count);
  endtask

  initial begin : stimulus
    logic [1:0] kinds [4] = '{nnact_pkg::KIND_SILU, nnact_pkg::KIND_GELU,
                              nnact_pkg::KIND_RELU, KIND_SPARE};
    for (int k = 0; k <= nnact_pkg::SEGMENTS; k++) begin
      silu_knots[k] = silu_at(-32768 + k * 1024);
      gelu_knots[k] = gelu_at(-32768 + k * 1024);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed words under every selector code, with no idling.
    foreach (kinds[i]) begin
      write_kind(kinds[i]);
      queue_directed();
    end

    run_phase(nnact_pkg::KIND_SILU, 60, 0, 0);
    run_phase(nnact_pkg::KIND_GELU, 60, 70, 0);
    run_phase(nnact_pkg::KIND_RELU, 60, 0, 70);
    run_phase(KIND_SPARE, 40, 8, 8);

    // The receiver holds off for a long stretch while words keep coming, so
    // the pipeline fills and the input side has to stall.
    run_phase(nnact_pkg::KIND_SILU, 60, 0, 0);
    @(negedge clk);
    hold_request = 1'b1;

    run_phase(nnact_pkg::KIND_GELU, 60, 8, 70);
    run_phase(nnact_pkg::KIND_SILU, 60, 70, 8);

    // Drain, then with the receiver always ready give stray words time to show.
    wait_idle();
    stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0 && activated_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
